// ===== rtl/core/thq_pkg.sv =====
// Shared types, widths and codes for the terrain height query block.
package thq_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_VERTICES_DEF  = 4096;
  localparam int FRACTION_BITS_DEF = 16;

  // Field and datapath widths
  localparam int COORD_W = 32;             // Q16.16 coordinate
  localparam int INDEX_W = 12;             // vertex slot field
  localparam int GRID_W  = 13;             // grid counts
  localparam int ITV_W   = 16;             // vertex interval
  localparam int EDGE_W  = COORD_W + 1;    // exact difference of two coordinates
  localparam int PROD_W  = 2 * EDGE_W;     // edge times edge
  localparam int NORM_W  = PROD_W + 1;     // normal component
  localparam int NUM_W   = 101;            // plane numerator
  localparam int QUOT_W  = 34;             // quotient bits kept before saturation

  // Result codes
  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_OUTSIDE    = 2'd1,
    STATUS_DEGENERATE = 2'd2
  } status_t;

  // Opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Register indexes
  localparam logic [1:0] REG_GRID_COUNT_X    = 2'd0;
  localparam logic [1:0] REG_GRID_COUNT_Z    = 2'd1;
  localparam logic [1:0] REG_VERTEX_INTERVAL = 2'd2;

  // Saturation limits of the height
  localparam logic [COORD_W-1:0] HEIGHT_MAX = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] HEIGHT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [GRID_W-1:0] grid_count_x;
    logic [GRID_W-1:0] grid_count_z;
    logic [ITV_W-1:0]  vertex_interval;
  } cfg_t;

  typedef struct packed {
    logic               is_query;
    logic [INDEX_W-1:0] vertex_index;
    logic [COORD_W-1:0] vertex_x;
    logic [COORD_W-1:0] vertex_y;
    logic [COORD_W-1:0] vertex_z;
    logic [COORD_W-1:0] query_x;
    logic [COORD_W-1:0] query_z;
  } item_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } vertex_t;

  // Four corners of the cell: c00 = base, c01 = base+1, c10 = next row, c11 = next row+1
  typedef struct packed {
    logic               oob;
    logic [COORD_W-1:0] query_x;
    logic [COORD_W-1:0] query_z;
    vertex_t            c00;
    vertex_t            c01;
    vertex_t            c10;
    vertex_t            c11;
  } corners_t;

  typedef struct packed {
    logic               oob;
    logic               flat;
    logic [COORD_W-1:0] p0y;
    logic [NUM_W-1:0]   num;
    logic [NORM_W-1:0]  ny;
  } plane_t;

  typedef struct packed {
    logic               oob;
    logic               flat;
    logic               neg;
    logic               ovf;
    logic [COORD_W-1:0] p0y;
    logic [QUOT_W-1:0]  quot;
  } quot_t;

  // Sign-extend a coordinate by one bit
  function automatic logic signed [EDGE_W-1:0] widen(input logic [COORD_W-1:0] v);
    return $signed({v[COORD_W-1], v});
  endfunction

endpackage

// ===== rtl/core/thq_cell_locate.sv =====
// Cell finder: pipelined divide by the vertex interval, bounds check, base index.
module thq_cell_locate #(
  parameter int MAX_VERTICES  = thq_pkg::MAX_VERTICES_DEF,
  parameter int FRACTION_BITS = thq_pkg::FRACTION_BITS_DEF,
  localparam int AW = $clog2(MAX_VERTICES)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  thq_pkg::cfg_t   cfg,
  input  logic            in_valid,
  input  thq_pkg::item_t  in_item,
  output logic            out_valid,
  output thq_pkg::item_t  out_item,
  output logic            out_oob,
  output logic [AW-1:0]   out_base
);

  localparam int COORD_W = thq_pkg::COORD_W;
  localparam int IW      = COORD_W - 1 - FRACTION_BITS;  // integer bits of a coordinate
  localparam int RW      = thq_pkg::ITV_W;
  localparam int BW      = IW + thq_pkg::GRID_W;
  localparam logic [RW-1:0] ITV_ONE = 1;

  logic [RW-1:0]  itv;
  logic           cfg_bad;
  logic           sv    [IW+1];
  thq_pkg::item_t sitem [IW+1];
  logic           sbad  [IW+1];
  logic [RW-1:0]  remx  [IW+1];
  logic [RW-1:0]  remz  [IW+1];
  logic [IW-1:0]  quox  [IW+1];
  logic [IW-1:0]  quoz  [IW+1];
  logic [IW-1:0]  col;
  logic [IW-1:0]  row;
  logic           past_x;
  logic           past_z;
  logic [BW-1:0]  base_full;

  // Zero interval counts as one; grid shape checks
  assign itv     = (cfg.vertex_interval == '0) ? ITV_ONE : cfg.vertex_interval;
  assign cfg_bad = (cfg.grid_count_x < 13'd2) || (cfg.grid_count_z < 13'd2) ||
                   ((32'(cfg.grid_count_x) * 32'(cfg.grid_count_z)) > 32'(MAX_VERTICES));

  // Entry stage
  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (en) begin
      sv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sitem[0] <= in_item;
      sbad[0]  <= cfg_bad || in_item.query_x[COORD_W-1] || in_item.query_z[COORD_W-1];
      remx[0]  <= '0;
      remz[0]  <= '0;
      quox[0]  <= '0;
      quoz[0]  <= '0;
    end
  end

  // One restoring quotient bit per stage, x and z side by side
  for (genvar k = 1; k <= IW; k++) begin : g_step
    logic [RW:0] trial_x;
    logic [RW:0] trial_z;
    logic        fit_x;
    logic        fit_z;

    assign trial_x = {remx[k-1], sitem[k-1].query_x[FRACTION_BITS + IW - k]};
    assign trial_z = {remz[k-1], sitem[k-1].query_z[FRACTION_BITS + IW - k]};
    assign fit_x   = trial_x >= {1'b0, itv};
    assign fit_z   = trial_z >= {1'b0, itv};

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k] <= 1'b0;
      end else if (en) begin
        sv[k] <= sv[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sitem[k] <= sitem[k-1];
        sbad[k]  <= sbad[k-1];
        remx[k]  <= fit_x ? RW'(trial_x - {1'b0, itv}) : trial_x[RW-1:0];
        remz[k]  <= fit_z ? RW'(trial_z - {1'b0, itv}) : trial_z[RW-1:0];
        quox[k]  <= quox[k-1] | (IW'(fit_x) << (IW - k));
        quoz[k]  <= quoz[k-1] | (IW'(fit_z) << (IW - k));
      end
    end
  end

  // Last row or column is outside; base = row * count_x + col
  assign col       = quox[IW];
  assign row       = quoz[IW];
  assign past_x    = 32'(col) >= (32'(cfg.grid_count_x) - 32'd1);
  assign past_z    = 32'(row) >= (32'(cfg.grid_count_z) - 32'd1);
  assign base_full = BW'(row) * BW'(cfg.grid_count_x) + BW'(col);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sv[IW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= sitem[IW];
      out_oob  <= sbad[IW] || past_x || past_z;
      out_base <= base_full[AW-1:0];
    end
  end

  // An in-grid query addresses only slots inside the store
  a_corner_in_store: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.is_query && !out_oob |->
      (32'(out_base) + 32'(cfg.grid_count_x) + 32'd1) < 32'(MAX_VERTICES))
    else $error("cell corner beyond vertex store");

endmodule

// ===== rtl/core/thq_vertex_store.sv =====
// Vertex store: two x/y/z memories, four corner reads per enabled cycle.
module thq_vertex_store #(
  parameter int MAX_VERTICES = thq_pkg::MAX_VERTICES_DEF,
  localparam int AW = $clog2(MAX_VERTICES)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic [thq_pkg::GRID_W-1:0]   grid_count_x,
  input  logic                         in_valid,
  input  thq_pkg::item_t               in_item,
  input  logic                         in_oob,
  input  logic [AW-1:0]                in_base,
  output logic                         out_valid,
  output thq_pkg::corners_t            out_corners
);

  thq_pkg::vertex_t mem_lo [MAX_VERTICES];  // serves the base row
  thq_pkg::vertex_t mem_hi [MAX_VERTICES];  // serves the next row

  logic [AW-1:0]    a00;
  logic [AW-1:0]    a01;
  logic [AW-1:0]    a10;
  logic [AW-1:0]    a11;
  logic [AW-1:0]    waddr;
  logic             wr;
  thq_pkg::vertex_t wdata;
  thq_pkg::vertex_t rd00;
  thq_pkg::vertex_t rd01;
  thq_pkg::vertex_t rd10;
  thq_pkg::vertex_t rd11;
  logic             oob_q;
  logic [thq_pkg::COORD_W-1:0] qx_q;
  logic [thq_pkg::COORD_W-1:0] qz_q;

  // Corner addresses
  assign a00 = in_base;
  assign a01 = AW'(32'(in_base) + 32'd1);
  assign a10 = AW'(32'(in_base) + 32'(grid_count_x));
  assign a11 = AW'(32'(in_base) + 32'(grid_count_x) + 32'd1);

  // Writes land at this stage so that later queries see them in order
  assign wr    = en && in_valid && (in_item.is_query == thq_pkg::OP_WRITE) &&
                 (32'(in_item.vertex_index) < 32'(MAX_VERTICES));
  assign waddr = AW'(in_item.vertex_index);
  assign wdata = {in_item.vertex_x, in_item.vertex_y, in_item.vertex_z};

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_lo[waddr] <= wdata;
    end
    if (en) begin
      rd00 <= mem_lo[a00];
      rd01 <= mem_lo[a01];
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_hi[waddr] <= wdata;
    end
    if (en) begin
      rd10 <= mem_hi[a10];
      rd11 <= mem_hi[a11];
    end
  end

  // Only queries continue past the store
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid && (in_item.is_query == thq_pkg::OP_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oob_q <= in_oob;
      qx_q  <= in_item.query_x;
      qz_q  <= in_item.query_z;
    end
  end

  assign out_corners = {oob_q, qx_q, qz_q, rd00, rd01, rd10, rd11};

endmodule

// ===== rtl/core/thq_plane_solve.sv =====
// Plane solver: triangle pick, edges, cross product normal, height numerator.
module thq_plane_solve (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  thq_pkg::corners_t  in_corners,
  output logic               out_valid,
  output thq_pkg::plane_t    out_plane
);

  localparam int COORD_W = thq_pkg::COORD_W;
  localparam int EDGE_W  = thq_pkg::EDGE_W;
  localparam int PROD_W  = thq_pkg::PROD_W;
  localparam int NORM_W  = thq_pkg::NORM_W;
  localparam int NUM_W   = thq_pkg::NUM_W;
  localparam int PART_W  = NORM_W;          // 34 x 33 partial product
  localparam int SUM_W   = PART_W + 1;

  // Stage 1: pick triangle, form edges
  thq_pkg::vertex_t          p0;
  thq_pkg::vertex_t          p1;
  thq_pkg::vertex_t          p2;
  logic signed [EDGE_W-1:0]  dxq;
  logic signed [EDGE_W-1:0]  dzq;
  logic signed [EDGE_W-1:0]  dzr;
  logic                      upper;

  logic                      v1;
  logic                      oob1;
  logic [COORD_W-1:0]        p0y1;
  logic signed [EDGE_W-1:0]  e1x, e1y, e1z, e2x, e2y, e2z, dx1, dz1;

  assign p0    = in_corners.c10;
  assign dxq   = thq_pkg::widen(in_corners.query_x) - thq_pkg::widen(p0.x);
  assign dzq   = thq_pkg::widen(in_corners.query_z) - thq_pkg::widen(p0.z);
  assign dzr   = thq_pkg::widen(p0.z) - thq_pkg::widen(in_corners.query_z);
  assign upper = dxq > dzr;
  assign p1    = upper ? in_corners.c11 : in_corners.c01;
  assign p2    = upper ? in_corners.c01 : in_corners.c00;

  always_ff @(posedge clk) begin
    if (en) begin
      oob1 <= in_corners.oob;
      p0y1 <= p0.y;
      e1x  <= thq_pkg::widen(p1.x) - thq_pkg::widen(p0.x);
      e1y  <= thq_pkg::widen(p1.y) - thq_pkg::widen(p0.y);
      e1z  <= thq_pkg::widen(p1.z) - thq_pkg::widen(p0.z);
      e2x  <= thq_pkg::widen(p2.x) - thq_pkg::widen(p0.x);
      e2y  <= thq_pkg::widen(p2.y) - thq_pkg::widen(p0.y);
      e2z  <= thq_pkg::widen(p2.z) - thq_pkg::widen(p0.z);
      dx1  <= dxq;
      dz1  <= dzq;
    end
  end

  // Stage 2: the six cross product terms
  logic                      v2;
  logic                      oob2;
  logic [COORD_W-1:0]        p0y2;
  logic signed [EDGE_W-1:0]  dx2, dz2;
  logic signed [PROD_W-1:0]  m0, m1, m2, m3, m4, m5;

  always_ff @(posedge clk) begin
    if (en) begin
      oob2 <= oob1;
      p0y2 <= p0y1;
      dx2  <= dx1;
      dz2  <= dz1;
      m0   <= e1y * e2z;
      m1   <= e1z * e2y;
      m2   <= e1z * e2x;
      m3   <= e1x * e2z;
      m4   <= e1x * e2y;
      m5   <= e1y * e2x;
    end
  end

  // Stage 3: normal components
  logic                      v3;
  logic                      oob3;
  logic [COORD_W-1:0]        p0y3;
  logic signed [EDGE_W-1:0]  dx3, dz3;
  logic signed [NORM_W-1:0]  nx3, ny3, nz3;

  always_ff @(posedge clk) begin
    if (en) begin
      oob3 <= oob2;
      p0y3 <= p0y2;
      dx3  <= dx2;
      dz3  <= dz2;
      nx3  <= NORM_W'(m0) - NORM_W'(m1);
      ny3  <= NORM_W'(m2) - NORM_W'(m3);
      nz3  <= NORM_W'(m4) - NORM_W'(m5);
    end
  end

  // Stage 4: split normal x and z into halves, partial products with the offsets
  logic signed [EDGE_W:0]    nx_hi, nx_lo, nz_hi, nz_lo;
  logic                      v4;
  logic                      oob4;
  logic                      flat4;
  logic [COORD_W-1:0]        p0y4;
  logic [NORM_W-1:0]         ny4;
  logic signed [PART_W-1:0]  pxh, pxl, pzh, pzl;

  assign nx_hi = nx3[NORM_W-1:EDGE_W];
  assign nx_lo = $signed({1'b0, nx3[EDGE_W-1:0]});
  assign nz_hi = nz3[NORM_W-1:EDGE_W];
  assign nz_lo = $signed({1'b0, nz3[EDGE_W-1:0]});

  always_ff @(posedge clk) begin
    if (en) begin
      oob4  <= oob3;
      flat4 <= (ny3 == '0);
      p0y4  <= p0y3;
      ny4   <= ny3;
      pxh   <= nx_hi * dx3;
      pxl   <= nx_lo * dx3;
      pzh   <= nz_hi * dz3;
      pzl   <= nz_lo * dz3;
    end
  end

  // Stage 5: sum the high and the low halves
  logic                      v5;
  logic                      oob5;
  logic                      flat5;
  logic [COORD_W-1:0]        p0y5;
  logic [NORM_W-1:0]         ny5;
  logic signed [SUM_W-1:0]   sum_hi, sum_lo;

  always_ff @(posedge clk) begin
    if (en) begin
      oob5   <= oob4;
      flat5  <= flat4;
      p0y5   <= p0y4;
      ny5    <= ny4;
      sum_hi <= SUM_W'(pxh) + SUM_W'(pzh);
      sum_lo <= SUM_W'(pxl) + SUM_W'(pzl);
    end
  end

  // Stage 6: numerator = hi * 2^33 + lo
  logic signed [NUM_W-1:0]   num6;

  always_ff @(posedge clk) begin
    if (en) begin
      out_plane.oob  <= oob5;
      out_plane.flat <= flat5;
      out_plane.p0y  <= p0y5;
      out_plane.ny   <= ny5;
      out_plane.num  <= num6;
    end
  end

  assign num6 = (NUM_W'(sum_hi) <<< EDGE_W) + NUM_W'(sum_lo);

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      out_valid <= v5;
    end
  end

endmodule

// ===== rtl/core/thq_quot_div.sv =====
// Quotient unit: magnitudes, overflow test, one restoring bit per stage.
module thq_quot_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  thq_pkg::plane_t   in_plane,
  output logic              out_valid,
  output thq_pkg::quot_t    out_quot
);

  localparam int COORD_W = thq_pkg::COORD_W;
  localparam int NORM_W  = thq_pkg::NORM_W;
  localparam int NUM_W   = thq_pkg::NUM_W;
  localparam int QUOT_W  = thq_pkg::QUOT_W;

  typedef struct packed {
    logic               oob;
    logic               flat;
    logic               neg;
    logic               ovf;
    logic [COORD_W-1:0] p0y;
  } tag_t;

  // Stage 0: signs and magnitudes
  logic               v0;
  tag_t               tag0;
  logic [NUM_W-1:0]   an0;
  logic [NORM_W-1:0]  ad0;

  always_ff @(posedge clk) begin
    if (en) begin
      tag0.oob  <= in_plane.oob;
      tag0.flat <= in_plane.flat;
      tag0.neg  <= in_plane.num[NUM_W-1] ^ in_plane.ny[NORM_W-1];
      tag0.ovf  <= 1'b0;
      tag0.p0y  <= in_plane.p0y;
      an0 <= in_plane.num[NUM_W-1] ? (NUM_W'(0) - in_plane.num) : in_plane.num;
      ad0 <= in_plane.ny[NORM_W-1] ? (NORM_W'(0) - in_plane.ny) : in_plane.ny;
    end
  end

  // Stage 1: quotient too large for the height range, partial remainder start
  logic               sv   [QUOT_W+1];
  tag_t               stag [QUOT_W+1];
  logic [NORM_W-1:0]  srem [QUOT_W+1];
  logic [NORM_W-1:0]  sad  [QUOT_W+1];
  logic [QUOT_W-1:0]  slow [QUOT_W+1];
  logic [QUOT_W-1:0]  squo [QUOT_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0    <= 1'b0;
      sv[0] <= 1'b0;
    end else if (en) begin
      v0    <= in_valid;
      sv[0] <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stag[0] <= '{oob:  tag0.oob,
                   flat: tag0.flat,
                   neg:  tag0.neg,
                   ovf:  (an0 >= {ad0, {QUOT_W{1'b0}}}),
                   p0y:  tag0.p0y};
      srem[0] <= an0[NUM_W-1:QUOT_W];
      sad[0]  <= ad0;
      slow[0] <= an0[QUOT_W-1:0];
      squo[0] <= '0;
    end
  end

  // Restoring steps, most significant quotient bit first
  for (genvar k = 1; k <= QUOT_W; k++) begin : g_step
    logic [NORM_W:0] trial;
    logic            fit;

    assign trial = {srem[k-1], slow[k-1][QUOT_W-k]};
    assign fit   = trial >= {1'b0, sad[k-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k] <= 1'b0;
      end else if (en) begin
        sv[k] <= sv[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stag[k] <= stag[k-1];
        sad[k]  <= sad[k-1];
        slow[k] <= slow[k-1];
        srem[k] <= fit ? NORM_W'(trial - {1'b0, sad[k-1]}) : trial[NORM_W-1:0];
        squo[k] <= squo[k-1] | (QUOT_W'(fit) << (QUOT_W - k));
      end
    end
  end

  assign out_valid      = sv[QUOT_W];
  assign out_quot.oob   = stag[QUOT_W].oob;
  assign out_quot.flat  = stag[QUOT_W].flat;
  assign out_quot.neg   = stag[QUOT_W].neg;
  assign out_quot.ovf   = stag[QUOT_W].ovf;
  assign out_quot.p0y   = stag[QUOT_W].p0y;
  assign out_quot.quot  = squo[QUOT_W];

  // A finished division leaves a remainder below the divisor
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    sv[QUOT_W] && !stag[QUOT_W].oob && !stag[QUOT_W].ovf && !stag[QUOT_W].flat |->
      srem[QUOT_W] < sad[QUOT_W])
    else $error("division remainder not below divisor");

endmodule

// ===== rtl/core/terrain_height_query.sv =====
// Top level of the terrain height query block.
// Terrain height query: load transactions (opcode 0) write one grid vertex, query
// transactions (opcode 1) return the height of the terrain at (query_x, query_z)
// together with a status (0 ok, 1 outside grid, 2 degenerate triangle). One
// transaction is accepted every cycle while not stalled; the whole datapath is one
// pipeline that advances whenever the output register is empty or being taken, so
// a stall holds every stage in place. A query passes 31 - FRACTION_BITS + 47
// register stages (62 at 16 fraction bits). The cell divide takes one stage per
// integer bit of the coordinate, the height divide one stage per quotient bit
// (34), the rest is store read, cross product and saturation. The vertex store
// is kept twice so that all four cell corners are read in the same cycle; a load
// takes effect in order with the queries around it. Configuration must be
// written only while no transaction is in flight.
module terrain_height_query #(
  parameter int MAX_VERTICES  = thq_pkg::MAX_VERTICES_DEF,
  parameter int FRACTION_BITS = thq_pkg::FRACTION_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [1:0]                           cfg_index,
  input  logic [thq_pkg::ITV_W-1:0]            cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 opcode,
  input  logic [thq_pkg::INDEX_W-1:0]          vertex_index,
  input  logic signed [thq_pkg::COORD_W-1:0]   vertex_x,
  input  logic signed [thq_pkg::COORD_W-1:0]   vertex_y,
  input  logic signed [thq_pkg::COORD_W-1:0]   vertex_z,
  input  logic signed [thq_pkg::COORD_W-1:0]   query_x,
  input  logic signed [thq_pkg::COORD_W-1:0]   query_z,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [thq_pkg::COORD_W-1:0]   height,
  output logic [1:0]                           status
);

  localparam int AW      = $clog2(MAX_VERTICES);
  localparam int COORD_W = thq_pkg::COORD_W;
  localparam int QUOT_W  = thq_pkg::QUOT_W;
  localparam int H_W     = QUOT_W + 2;

  thq_pkg::cfg_t     cfg;
  logic              en;
  thq_pkg::item_t    item;

  logic              loc_valid;
  thq_pkg::item_t    loc_item;
  logic              loc_oob;
  logic [AW-1:0]     loc_base;

  logic              st_valid;
  thq_pkg::corners_t st_corners;

  logic              pl_valid;
  thq_pkg::plane_t   pl_plane;

  logic              dv_valid;
  thq_pkg::quot_t    dv_quot;

  logic signed [QUOT_W:0] qs;
  logic              v1;
  logic              oob1;
  logic              flat1;
  logic              ovf1;
  logic              neg1;
  logic signed [H_W-1:0] h1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_count_x    <= 13'd64;
      cfg.grid_count_z    <= 13'd64;
      cfg.vertex_interval <= 16'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        thq_pkg::REG_GRID_COUNT_X:    cfg.grid_count_x    <= cfg_data[thq_pkg::GRID_W-1:0];
        thq_pkg::REG_GRID_COUNT_Z:    cfg.grid_count_z    <= cfg_data[thq_pkg::GRID_W-1:0];
        thq_pkg::REG_VERTEX_INTERVAL: cfg.vertex_interval <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline advances when the output register is empty or being taken
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  assign item = {(opcode == thq_pkg::OP_QUERY), vertex_index, vertex_x, vertex_y,
                 vertex_z, query_x, query_z};

  thq_cell_locate #(
    .MAX_VERTICES  (MAX_VERTICES),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_locate (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_item   (item),
    .out_valid (loc_valid),
    .out_item  (loc_item),
    .out_oob   (loc_oob),
    .out_base  (loc_base)
  );

  thq_vertex_store #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_store (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .grid_count_x (cfg.grid_count_x),
    .in_valid     (loc_valid),
    .in_item      (loc_item),
    .in_oob       (loc_oob),
    .in_base      (loc_base),
    .out_valid    (st_valid),
    .out_corners  (st_corners)
  );

  thq_plane_solve u_plane (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (st_valid),
    .in_corners (st_corners),
    .out_valid  (pl_valid),
    .out_plane  (pl_plane)
  );

  thq_quot_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pl_valid),
    .in_plane  (pl_plane),
    .out_valid (dv_valid),
    .out_quot  (dv_quot)
  );

  // Signed quotient and height before saturation
  assign qs = dv_quot.neg ? -$signed({1'b0, dv_quot.quot}) : $signed({1'b0, dv_quot.quot});

  always_ff @(posedge clk) begin
    if (en) begin
      oob1  <= dv_quot.oob;
      flat1 <= dv_quot.flat;
      ovf1  <= dv_quot.ovf;
      neg1  <= dv_quot.neg;
      h1    <= H_W'(thq_pkg::widen(dv_quot.p0y)) - H_W'(qs);
    end
  end

  // Output register: status, saturation
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= dv_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (oob1) begin
        height <= '0;
        status <= thq_pkg::STATUS_OUTSIDE;
      end else if (flat1) begin
        height <= '0;
        status <= thq_pkg::STATUS_DEGENERATE;
      end else if (ovf1) begin
        // huge positive quotient drives the height down
        height <= neg1 ? thq_pkg::HEIGHT_MAX : thq_pkg::HEIGHT_MIN;
        status <= thq_pkg::STATUS_OK;
      end else if ((h1[H_W-1:COORD_W-1] != '0) && (h1[H_W-1:COORD_W-1] != '1)) begin
        height <= h1[H_W-1] ? thq_pkg::HEIGHT_MIN : thq_pkg::HEIGHT_MAX;
        status <= thq_pkg::STATUS_OK;
      end else begin
        height <= h1[COORD_W-1:0];
        status <= thq_pkg::STATUS_OK;
      end
    end
  end

  // Any failing status reports a zero height
  a_zero_height_on_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != thq_pkg::STATUS_OK) |-> (height == '0))
    else $error("nonzero height with error status");

endmodule
